/* rtl/core/wire_chamber_hit_histogrammer_macros.svh */
// Assertion helpers for the histogrammer modules; wchh_ctrl is the one that uses them.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef WIRE_CHAMBER_HIT_HISTOGRAMMER_MACROS_SVH
`define WIRE_CHAMBER_HIT_HISTOGRAMMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WCHH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WCHH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/wchh_pkg.sv */
package wchh_pkg;

    localparam int X_PADS_DEF     = 64;
    localparam int Y_PADS_DEF     = 40;
    localparam int COUNT_BITS_DEF = 32;

    localparam int XY_STRIDE   = 64;
    localparam int STRIDE_BITS = $clog2(XY_STRIDE);

    localparam int KIND_W    = 2;
    localparam int PLANE_W   = 2;
    localparam int PAD_W     = 7;
    localparam int CHARGE_W  = 16;
    localparam int SEL_W     = 2;
    localparam int BIN_W     = 12;
    localparam int OUT_W     = 32;
    localparam int EVENT_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 2;
    localparam int PROD_W    = 20;

    localparam logic [PLANE_W-1:0] X_PLANE_RESET = 2'd1;
    localparam logic [PLANE_W-1:0] Y_PLANE_RESET = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT   = 2'd0,
        KIND_EOE   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [SEL_W-1:0] {
        SEL_X  = 2'd0,
        SEL_Y  = 2'd1,
        SEL_XY = 2'd2
    } sel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_PLANE = 1'd0,
        CFG_Y_PLANE = 1'd1
    } cfg_idx_t;

    typedef struct packed {
        logic take;
        logic commit;
        logic load;
        logic sweep;
        logic sweep_init;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/core/wchh_datapath.sv */
module wchh_datapath #(
    parameter int X_PADS     = wchh_pkg::X_PADS_DEF,
    parameter int Y_PADS     = wchh_pkg::Y_PADS_DEF,
    parameter int COUNT_BITS = wchh_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [wchh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wchh_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic [wchh_pkg::KIND_W-1:0]      kind,
    input  logic [wchh_pkg::PLANE_W-1:0]     plane,
    input  logic [wchh_pkg::PAD_W-1:0]       pad,
    input  logic [wchh_pkg::CHARGE_W-1:0]    charge,
    input  logic [wchh_pkg::SEL_W-1:0]       hist_select,
    input  logic [wchh_pkg::BIN_W-1:0]       bin_index,
    input  logic                             out_ready,
    input  wchh_pkg::dp_cmd_t                cmd,
    output wchh_pkg::dp_stat_t               stat,
    output logic                             out_valid,
    output logic [wchh_pkg::OUT_W-1:0]       bin_count,
    output logic [wchh_pkg::EVENT_W-1:0]     events_seen
);
    import wchh_pkg::*;

    localparam int XAW      = (X_PADS > 1) ? $clog2(X_PADS) : 1;
    localparam int YAW      = (Y_PADS > 1) ? $clog2(Y_PADS) : 1;
    localparam int XY_DEPTH = X_PADS * Y_PADS;
    localparam int XYAW     = (XY_DEPTH > 1) ? $clog2(XY_DEPTH) : 1;
    localparam logic [COUNT_BITS-1:0] BIN_MAX   = '1;
    localparam logic [EVENT_W-1:0]    EVENT_MAX = '1;

    logic [COUNT_BITS-1:0] x_mem  [X_PADS];
    logic [COUNT_BITS-1:0] y_mem  [Y_PADS];
    logic [COUNT_BITS-1:0] xy_mem [XY_DEPTH];
    logic [COUNT_BITS-1:0] x_rdata_reg;
    logic [COUNT_BITS-1:0] y_rdata_reg;
    logic [COUNT_BITS-1:0] xy_rdata_reg;

    logic [PLANE_W-1:0]  x_plane_reg;
    logic [PLANE_W-1:0]  y_plane_reg;
    logic                x_found_reg;
    logic [PAD_W-1:0]    best_x_pad_reg;
    logic [CHARGE_W-1:0] best_x_charge_reg;
    logic                y_found_reg;
    logic [PAD_W-1:0]    best_y_pad_reg;
    logic [CHARGE_W-1:0] best_y_charge_reg;
    logic [EVENT_W-1:0]  event_count_reg;
    logic [XYAW-1:0]     sweep_cnt_reg;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    bin_count_reg;
    logic [EVENT_W-1:0]  events_reg;

    logic                x_ok_reg;
    logic                y_ok_reg;
    logic                xy_ok_reg;
    logic                rd_ok_reg;
    logic [SEL_W-1:0]    sel_reg;
    logic [XAW-1:0]      x_addr_reg;
    logic [YAW-1:0]      y_addr_reg;
    logic [XYAW-1:0]     xy_addr_reg;

    logic                   is_hit;
    logic                   is_eoe;
    logic                   is_read;
    logic                   x_sel;
    logic                   y_sel;
    logic                   x_pad_ok;
    logic                   y_pad_ok;
    logic [PAD_W-1:0]       pad_m1;
    logic [STRIDE_BITS-1:0] col;
    logic [BIN_W-STRIDE_BITS-1:0] row;
    logic                   rd_ok;
    logic                   xy_ok;
    logic [PROD_W-1:0]      rd_prod;
    logic [PROD_W-1:0]      eoe_prod;
    logic [XAW-1:0]         x_raddr;
    logic [YAW-1:0]         y_raddr;
    logic [XYAW-1:0]        xy_raddr;
    logic                   x_we;
    logic                   y_we;
    logic                   xy_we;
    logic [XAW-1:0]         x_waddr;
    logic [YAW-1:0]         y_waddr;
    logic [XYAW-1:0]        xy_waddr;
    logic [COUNT_BITS-1:0]  x_wdata;
    logic [COUNT_BITS-1:0]  y_wdata;
    logic [COUNT_BITS-1:0]  xy_wdata;
    logic [OUT_W-1:0]       result;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == BIN_MAX) ? v : v + 1'b1;
    endfunction

    always_comb
    begin
        is_hit   = (kind == KIND_HIT);
        is_eoe   = (kind == KIND_EOE);
        is_read  = (kind == KIND_READ);
        x_sel    = (plane == x_plane_reg);
        y_sel    = (plane == y_plane_reg);
        pad_m1   = pad - 1'b1;
        x_pad_ok = (pad != '0) && (pad <= PAD_W'(X_PADS));
        y_pad_ok = (pad != '0) && (pad <= PAD_W'(Y_PADS));
        col      = bin_index[STRIDE_BITS-1:0];
        row      = bin_index[BIN_W-1:STRIDE_BITS];
        rd_prod  = PROD_W'(row) * PROD_W'(X_PADS) + PROD_W'(col);
        eoe_prod = PROD_W'(best_y_pad_reg - 1'b1) * PROD_W'(X_PADS)
                 + PROD_W'(best_x_pad_reg - 1'b1);
        xy_ok    = x_found_reg && y_found_reg
                 && (best_x_pad_reg != '0) && (best_x_pad_reg <= PAD_W'(X_PADS))
                 && (best_y_pad_reg != '0) && (best_y_pad_reg <= PAD_W'(Y_PADS));
        case (hist_select)
            SEL_X:   rd_ok = (bin_index < BIN_W'(X_PADS));
            SEL_Y:   rd_ok = (bin_index < BIN_W'(Y_PADS));
            SEL_XY:  rd_ok = (PAD_W'(col) < PAD_W'(X_PADS)) && (PAD_W'(row) < PAD_W'(Y_PADS));
            default: rd_ok = 1'b0;
        endcase
        x_raddr  = is_read ? bin_index[XAW-1:0] : pad_m1[XAW-1:0];
        y_raddr  = is_read ? bin_index[YAW-1:0] : pad_m1[YAW-1:0];
        xy_raddr = is_read ? rd_prod[XYAW-1:0] : eoe_prod[XYAW-1:0];
    end

    always_comb
    begin
        if (cmd.sweep)
        begin
            x_we     = ({1'b0, sweep_cnt_reg} < (XYAW + 1)'(X_PADS));
            y_we     = ({1'b0, sweep_cnt_reg} < (XYAW + 1)'(Y_PADS));
            xy_we    = 1'b1;
            x_waddr  = sweep_cnt_reg[XAW-1:0];
            y_waddr  = sweep_cnt_reg[YAW-1:0];
            xy_waddr = sweep_cnt_reg;
            x_wdata  = '0;
            y_wdata  = '0;
            xy_wdata = '0;
        end
        else
        begin
            x_we     = cmd.commit && x_ok_reg;
            y_we     = cmd.commit && y_ok_reg;
            xy_we    = cmd.commit && xy_ok_reg;
            x_waddr  = x_addr_reg;
            y_waddr  = y_addr_reg;
            xy_waddr = xy_addr_reg;
            x_wdata  = sat_inc(x_rdata_reg);
            y_wdata  = sat_inc(y_rdata_reg);
            xy_wdata = sat_inc(xy_rdata_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
            x_mem[x_waddr] <= x_wdata;
        if (cmd.take)
            x_rdata_reg <= x_mem[x_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (y_we)
            y_mem[y_waddr] <= y_wdata;
        if (cmd.take)
            y_rdata_reg <= y_mem[y_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (xy_we)
            xy_mem[xy_waddr] <= xy_wdata;
        if (cmd.take)
            xy_rdata_reg <= xy_mem[xy_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            x_ok_reg    <= is_hit && x_sel && x_pad_ok;
            y_ok_reg    <= is_hit && y_sel && y_pad_ok;
            xy_ok_reg   <= is_eoe && xy_ok;
            rd_ok_reg   <= rd_ok;
            sel_reg     <= hist_select;
            x_addr_reg  <= x_raddr;
            y_addr_reg  <= y_raddr;
            xy_addr_reg <= xy_raddr;
        end
    end

    always_comb
    begin
        result = '0;
        if (rd_ok_reg)
        begin
            case (sel_reg)
                SEL_X:   result = OUT_W'(x_rdata_reg);
                SEL_Y:   result = OUT_W'(y_rdata_reg);
                SEL_XY:  result = OUT_W'(xy_rdata_reg);
                default: result = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_plane_reg       <= X_PLANE_RESET;
            y_plane_reg       <= Y_PLANE_RESET;
            x_found_reg       <= 1'b0;
            best_x_pad_reg    <= '0;
            best_x_charge_reg <= '0;
            y_found_reg       <= 1'b0;
            best_y_pad_reg    <= '0;
            best_y_charge_reg <= '0;
            event_count_reg   <= '0;
            sweep_cnt_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_X_PLANE: x_plane_reg <= cfg_data[PLANE_W-1:0];
                    CFG_Y_PLANE: y_plane_reg <= cfg_data[PLANE_W-1:0];
                    default:     ;
                endcase
            end
            if (cmd.take && is_hit)
            begin
                if (x_sel && (charge > best_x_charge_reg))
                begin
                    x_found_reg       <= 1'b1;
                    best_x_pad_reg    <= pad;
                    best_x_charge_reg <= charge;
                end
                if (y_sel && (charge > best_y_charge_reg))
                begin
                    y_found_reg       <= 1'b1;
                    best_y_pad_reg    <= pad;
                    best_y_charge_reg <= charge;
                end
            end
            if (cmd.take && is_eoe)
            begin
                x_found_reg       <= 1'b0;
                best_x_pad_reg    <= '0;
                best_x_charge_reg <= '0;
                y_found_reg       <= 1'b0;
                best_y_pad_reg    <= '0;
                best_y_charge_reg <= '0;
                if (event_count_reg != EVENT_MAX)
                    event_count_reg <= event_count_reg + 1'b1;
            end
            if (cmd.sweep_init)
                sweep_cnt_reg <= '0;
            else if (cmd.sweep)
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_count_reg <= result;
            events_reg    <= event_count_reg;
        end
    end

    assign stat.sweep_done = (sweep_cnt_reg == XYAW'(XY_DEPTH - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign bin_count       = bin_count_reg;
    assign events_seen     = events_reg;

endmodule

/* rtl/core/wchh_ctrl.sv */
`include "wire_chamber_hit_histogrammer_macros.svh"

module wchh_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [wchh_pkg::KIND_W-1:0] kind,
    input  wchh_pkg::dp_stat_t          stat,
    output logic                        in_ready,
    output wchh_pkg::dp_cmd_t           cmd
);
    import wchh_pkg::*;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_COMMIT,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    unique case (kind) inside
                        KIND_HIT, KIND_EOE:
                            state_next = S_COMMIT;
                        KIND_READ:
                            state_next = S_RESULT;
                        default:
                        begin
                            cmd.sweep_init = 1'b1;
                            state_next     = S_SWEEP;
                        end
                    endcase
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_SWEEP;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

    `WCHH_ASSERT_NEXT(a_read_goes_to_result, in_valid && in_ready_reg && kind == KIND_READ, state_reg == S_RESULT, "read beat did not reach the result state")
    `WCHH_ASSERT_NEXT(a_update_commits, in_valid && in_ready_reg && (kind == KIND_HIT || kind == KIND_EOE), cmd.commit, "hit or end-of-event beat was not written back")
    `WCHH_ASSERT_NEXT(a_sweep_reopens, state_reg == S_SWEEP && stat.sweep_done, in_ready_reg, "input did not reopen after the clearing sweep")
    `WCHH_ASSERT_NOW(a_no_take_while_busy, cmd.sweep || cmd.commit || cmd.load, !cmd.take, "beat taken while memory work was pending")

endmodule

/* rtl/core/wire_chamber_hit_histogrammer.sv */
// Hit, end-of-event and read beats drop in_ready until the controller is idle again.
// A hit or end-of-event beat reads its bins when accepted and writes them back next cycle.
// A read beat loads the output register in the result state, which holds there while the
// previous result is still waiting. Configuration writes are taken always.
// A clear beat sweeps one 2-D bin per cycle over all X_PADS*Y_PADS bins (2560 by default)
// with in_ready low; after reset (rst_n, asynchronous) the same sweep runs first.
module wire_chamber_hit_histogrammer #(
    parameter int X_PADS     = wchh_pkg::X_PADS_DEF,
    parameter int Y_PADS     = wchh_pkg::Y_PADS_DEF,
    parameter int COUNT_BITS = wchh_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [wchh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wchh_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [wchh_pkg::KIND_W-1:0]      kind,
    input  logic [wchh_pkg::PLANE_W-1:0]     plane,
    input  logic [wchh_pkg::PAD_W-1:0]       pad,
    input  logic [wchh_pkg::CHARGE_W-1:0]    charge,
    input  logic [wchh_pkg::SEL_W-1:0]       hist_select,
    input  logic [wchh_pkg::BIN_W-1:0]       bin_index,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [wchh_pkg::OUT_W-1:0]       bin_count,
    output logic [wchh_pkg::EVENT_W-1:0]     events_seen
);
    import wchh_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    wchh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    wchh_datapath #(
        .X_PADS     (X_PADS),
        .Y_PADS     (Y_PADS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .plane       (plane),
        .pad         (pad),
        .charge      (charge),
        .hist_select (hist_select),
        .bin_index   (bin_index),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .bin_count   (bin_count),
        .events_seen (events_seen)
    );

endmodule
